>>> rtl/rbr_pkg.sv
package rbr_pkg;

    localparam int BUFFER_DEPTH = 512;
    localparam int MAX_PACKET   = 64;

    localparam int ADDR_W  = $clog2(BUFFER_DEPTH);
    localparam int OFF_W   = $clog2(MAX_PACKET + 1);
    localparam int LEN_W   = 7;
    localparam int POFF_W  = 9;
    localparam int FILL_W  = 9;
    localparam int VALUE_W = 16;
    localparam int TMR_W   = 16;
    localparam int BYTE_W  = 8;

    typedef enum logic [2:0] {
        REQ_BYTE   = 3'd0,
        REQ_TICK   = 3'd1,
        REQ_READ   = 3'd2,
        REQ_PEEK_B = 3'd3,
        REQ_PEEK_W = 3'd4,
        REQ_FLUSH  = 3'd5,
        REQ_FILL   = 3'd6
    } t_req;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_READ    = 2'd1,
        KIND_PEEK    = 2'd2,
        KIND_TIMEOUT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_PEEK_B,
        ST_PEEK_LO,
        ST_PEEK_HI
    } t_state;

    typedef struct packed {
        t_kind               kind;
        logic [VALUE_W-1:0]  value;
        logic                last;
        logic [FILL_W-1:0]   fill;
        logic                accepted;
    } t_result;

    typedef struct packed {
        logic               cfg_we;
        logic [TMR_W-1:0]   cfg_data;
        logic               tick;
        logic               commit;
    } t_tmr_ctl;

endpackage

>>> rtl/rbr_ram.sv
module rbr_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rbr_timer.sv
module rbr_timer import rbr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_tmr_ctl i_ctl,
    output logic     o_fire
);

    logic             r_armed;
    logic             n_armed;
    logic [TMR_W-1:0] r_ticks;
    logic [TMR_W-1:0] n_ticks;
    logic [TMR_W-1:0] r_timeout;
    logic [TMR_W-1:0] n_timeout;
    logic             expiring;

    assign expiring = r_armed && (r_ticks <= TMR_W'(1));
    assign o_fire   = i_ctl.tick && expiring;

    always_comb begin
        n_armed   = r_armed;
        n_ticks   = r_ticks;
        n_timeout = r_timeout;
        if (i_ctl.cfg_we) begin
            n_timeout = i_ctl.cfg_data;
            n_armed   = 1'b0;
        end else if (i_ctl.commit) begin
            if (r_timeout != '0) begin
                n_armed = 1'b1;
                n_ticks = r_timeout;
            end else begin
                n_armed = 1'b0;
            end
        end else if (i_ctl.tick && r_armed) begin
            if (expiring) begin
                n_ticks = '0;
                n_armed = 1'b0;
            end else begin
                n_ticks = r_ticks - TMR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= 1'b0;
            r_ticks   <= '0;
            r_timeout <= '0;
        end else begin
            r_armed   <= n_armed;
            r_ticks   <= n_ticks;
            r_timeout <= n_timeout;
        end
    end

    // expiry always leaves the counter disarmed
    a_fire_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fire |=> !r_armed)
        else $error("timer still armed after expiry");

    // a commit with a nonzero timeout loads and arms
    a_commit_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.commit && !i_ctl.cfg_we && r_timeout != '0)
            |=> (r_armed && r_ticks == $past(r_timeout)))
        else $error("commit did not rearm the timer");

endmodule

>>> rtl/rbr_outbuf.sv
module rbr_outbuf import rbr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_data,
    input  logic       i_pop,
    output logic       o_valid,
    output t_result    o_data,
    output logic [1:0] o_count
);

    t_result    r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_rd];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    // a push into a full buffer is only legal while the head leaves
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_count == 2'd2) |-> i_pop)
        else $error("result buffer overflow");

endmodule

>>> rtl/rx_byte_ring_with_idle_timeout.sv
// Receive byte ring of BUFFER_DEPTH bytes with an idle timeout. Packets arrive one byte
// per word (tuser = request 0); the first byte decides whether the whole packet fits and
// the last byte commits the write pointer and rearms the idle timer from timeout_ticks.
// Ticks (request 1) count the timer down and report a timeout with the fill count on
// expiry. Read block pops up to MAX_PACKET bytes as one result word each, peeks return a
// byte or a little-endian word at an offset from the read pointer, flush empties the ring
// and query returns the fill. Packet byte, tick, flush, query and zero-length read are
// answered from the idle state; peeks read their bytes in turn, each one pass through
// the single read port of the ring memory; a read block sends one byte per cycle out of
// that port while the result buffer has room. After reset the ring memory is swept to
// zero, one entry per cycle, over all BUFFER_DEPTH (512) entries before the first word
// is taken; timeout_ticks writes are taken during that sweep. Results go through a
// two-word output buffer, so backpressure on the result side only stalls input when it
// is full. Write timeout_ticks only while the block is idle; writing it disarms the timer.
module rx_byte_ring_with_idle_timeout import rbr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [7:0] data_byte, [14:8] packet_length, [15] first_of_packet,
    // [22:16] read_length, [31:23] peek_offset
    input  logic [31:0]  i_s_axis_tdata,
    input  logic         i_s_axis_tlast,   // last_of_packet
    input  logic [2:0]   i_s_axis_tuser,   // req_type
    // result stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [15:0] value, [24:16] fill_count, [25] packet_accepted, [31:26] zero
    output logic [31:0]  o_m_axis_tdata,
    output logic         o_m_axis_tlast,   // last_result
    output logic [1:0]   o_m_axis_tuser,   // result_kind
    // timeout_ticks register
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata
);

    // input word fields
    logic [BYTE_W-1:0] in_data;
    logic [LEN_W-1:0]  in_plen;
    logic              in_first;
    logic              in_last;
    logic [LEN_W-1:0]  in_rlen;
    logic [POFF_W-1:0] in_poff;
    t_req              in_req;
    logic              in_acc;

    assign in_data  = i_s_axis_tdata[7:0];
    assign in_plen  = i_s_axis_tdata[14:8];
    assign in_first = i_s_axis_tdata[15];
    assign in_rlen  = i_s_axis_tdata[22:16];
    assign in_poff  = i_s_axis_tdata[31:23];
    assign in_last  = i_s_axis_tlast;
    assign in_req   = t_req'(i_s_axis_tuser);

    // control and pointer state
    t_state             r_state,    n_state;
    logic [ADDR_W-1:0]  r_rp,       n_rp;
    logic [ADDR_W-1:0]  r_wp,       n_wp;
    logic [OFF_W-1:0]   r_off,      n_off;
    logic               r_taking,   n_taking;
    logic [ADDR_W-1:0]  r_clr,      n_clr;
    logic [LEN_W-1:0]   r_left,     n_left;
    logic [ADDR_W-1:0]  r_raddr,    n_raddr;
    logic               r_inflight, n_inflight;
    logic               r_rlast,    n_rlast;
    logic [BYTE_W-1:0]  r_lo,       n_lo;

    // ring memory port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    // result buffer
    logic       push;
    t_result    push_data;
    logic       pop;
    logic       ob_valid;
    t_result    ob_data;
    logic [1:0] ob_count;

    // timer
    t_tmr_ctl tmr_ctl;
    logic     tmr_fire;

    // packet byte decode
    logic [ADDR_W-1:0] fill_cur;
    logic [ADDR_W-1:0] free_space;
    logic              pkt_fits;
    logic              eff_taking;
    logic [OFF_W-1:0]  eff_off;
    logic              stored;
    logic [OFF_W-1:0]  off_after;
    logic [LEN_W-1:0]  rd_len;
    logic [ADDR_W-1:0] peek_addr;
    logic [1:0]        slots_used;
    logic              issue_ok;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign pop      = o_m_axis_tvalid && i_m_axis_tready;
    assign fill_cur = r_wp - r_rp;

    assign free_space = ADDR_W'(BUFFER_DEPTH - 1) - fill_cur;
    assign pkt_fits   = (in_plen != '0) && (in_plen <= LEN_W'(MAX_PACKET))
                        && ((ADDR_W + 1)'(in_plen) < (ADDR_W + 1)'(free_space));
    assign eff_taking = in_first ? pkt_fits : r_taking;
    assign eff_off    = in_first ? '0 : r_off;
    assign stored     = eff_taking && (LEN_W'(eff_off) < in_plen)
                        && (eff_off < OFF_W'(MAX_PACKET));
    assign off_after  = eff_off + OFF_W'(stored);

    // read block saturates at one packet
    assign rd_len    = (in_rlen > LEN_W'(MAX_PACKET)) ? LEN_W'(MAX_PACKET) : in_rlen;
    assign peek_addr = r_rp + ADDR_W'(in_poff);

    // a read may start when its byte will find room in the result buffer
    assign slots_used = ob_count + 2'(r_inflight);
    assign issue_ok   = (slots_used < 2'd2) || ((slots_used == 2'd2) && pop);

    assign o_s_axis_tready = (r_state == ST_IDLE) && !r_inflight && (ob_count < 2'd2);

    always_comb begin
        n_state    = r_state;
        n_rp       = r_rp;
        n_wp       = r_wp;
        n_off      = r_off;
        n_taking   = r_taking;
        n_clr      = r_clr;
        n_left     = r_left;
        n_raddr    = r_raddr;
        n_inflight = 1'b0;
        n_rlast    = r_rlast;
        n_lo       = r_lo;

        mem_we    = 1'b0;
        mem_waddr = r_wp + ADDR_W'(eff_off);
        mem_wdata = in_data;
        mem_re    = 1'b0;
        mem_raddr = r_raddr;

        tmr_ctl.cfg_we   = i_cfg_we;
        tmr_ctl.cfg_data = i_cfg_wdata;
        tmr_ctl.tick     = 1'b0;
        tmr_ctl.commit   = 1'b0;

        // byte coming back from the read stream
        push               = r_inflight;
        push_data.kind     = KIND_READ;
        push_data.value    = VALUE_W'(mem_rdata);
        push_data.last     = r_rlast;
        push_data.accepted = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + ADDR_W'(1);
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    push               = 1'b1;
                    push_data.kind     = KIND_ACK;
                    push_data.value    = '0;
                    push_data.last     = 1'b1;
                    push_data.accepted = 1'b0;
                    case (in_req)
                        REQ_BYTE: begin
                            mem_we             = stored;
                            n_off              = off_after;
                            n_taking           = eff_taking;
                            push_data.accepted = stored;
                            if (eff_taking && in_last) begin
                                n_wp           = r_wp + ADDR_W'(off_after);
                                n_taking       = 1'b0;
                                n_off          = '0;
                                tmr_ctl.commit = 1'b1;
                            end
                        end
                        REQ_TICK: begin
                            tmr_ctl.tick = 1'b1;
                            if (tmr_fire) begin
                                push_data.kind  = KIND_TIMEOUT;
                                push_data.value = VALUE_W'(fill_cur);
                            end
                        end
                        REQ_READ: begin
                            if (rd_len != '0) begin
                                push    = 1'b0;
                                n_rp    = r_rp + ADDR_W'(rd_len);
                                n_left  = rd_len;
                                n_raddr = r_rp;
                                n_state = ST_READ;
                            end
                        end
                        REQ_PEEK_B: begin
                            push      = 1'b0;
                            mem_re    = 1'b1;
                            mem_raddr = peek_addr;
                            n_state   = ST_PEEK_B;
                        end
                        REQ_PEEK_W: begin
                            push      = 1'b0;
                            mem_re    = 1'b1;
                            mem_raddr = peek_addr;
                            n_raddr   = peek_addr + ADDR_W'(1);
                            n_state   = ST_PEEK_LO;
                        end
                        REQ_FLUSH: begin
                            n_rp = r_wp;
                        end
                        REQ_FILL: begin
                            push_data.value = VALUE_W'(fill_cur);
                        end
                        default: begin
                            // unused request code: plain acknowledge
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (issue_ok) begin
                    mem_re     = 1'b1;
                    n_raddr    = r_raddr + ADDR_W'(1);
                    n_left     = r_left - LEN_W'(1);
                    n_inflight = 1'b1;
                    n_rlast    = (r_left == LEN_W'(1));
                    if (r_left == LEN_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_PEEK_B: begin
                push            = 1'b1;
                push_data.kind  = KIND_PEEK;
                push_data.value = VALUE_W'(mem_rdata);
                push_data.last  = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_PEEK_LO: begin
                n_lo    = mem_rdata;
                mem_re  = 1'b1;
                n_state = ST_PEEK_HI;
            end
            ST_PEEK_HI: begin
                push            = 1'b1;
                push_data.kind  = KIND_PEEK;
                push_data.value = {mem_rdata, r_lo};
                push_data.last  = 1'b1;
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // fill after the step; pointers hold still while a result is pending
        push_data.fill = FILL_W'(n_wp - n_rp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_rp       <= '0;
            r_wp       <= '0;
            r_off      <= '0;
            r_taking   <= 1'b0;
            r_clr      <= '0;
            r_left     <= '0;
            r_inflight <= 1'b0;
            r_rlast    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rp       <= n_rp;
            r_wp       <= n_wp;
            r_off      <= n_off;
            r_taking   <= n_taking;
            r_clr      <= n_clr;
            r_left     <= n_left;
            r_inflight <= n_inflight;
            r_rlast    <= n_rlast;
        end
    end

    // read address and peek low byte carry no control meaning
    always_ff @(posedge i_clk) begin
        r_raddr <= n_raddr;
        r_lo    <= n_lo;
    end

    rbr_ram #(
        .DEPTH (BUFFER_DEPTH),
        .WIDTH (BYTE_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rbr_timer u_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tmr_ctl),
        .o_fire  (tmr_fire)
    );

    rbr_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_valid (ob_valid),
        .o_data  (ob_data),
        .o_count (ob_count)
    );

    assign o_m_axis_tvalid = ob_valid;
    assign o_m_axis_tdata  = {6'b0, ob_data.accepted, ob_data.fill, ob_data.value};
    assign o_m_axis_tlast  = ob_data.last;
    assign o_m_axis_tuser  = ob_data.kind;

    // a peek holds off the next request word while the memory answers
    a_peek_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (in_req == REQ_PEEK_B || in_req == REQ_PEEK_W)) |=> !o_s_axis_tready)
        else $error("request taken while a peek is pending");

endmodule

>>> dv/rx_byte_ring_with_idle_timeout_tb.sv
module rx_byte_ring_with_idle_timeout_tb;
    import rbr_pkg::*;

    // request 7 is not decoded by the block and must come back as a plain ack
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    // one request word as the sender sees it, before packing onto the bus
    typedef struct packed {
        logic [2:0]        req;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  plen;
        logic              first;
        logic              last;
        logic [LEN_W-1:0]  rlen;
        logic [POFF_W-1:0] poff;
    } t_req_word;

    // directed row: the word, and a typed result where it is obvious by eye
    typedef struct packed {
        t_req_word w;
        logic      typed;
        t_result   want;
    } t_dir_row;

    localparam t_result ACK_EMPTY = '{KIND_ACK, 16'h0000, 1'b1, 9'd0, 1'b0};
    localparam t_result PEEK_ZERO = '{KIND_PEEK, 16'h0000, 1'b1, 9'd0, 1'b0};
    localparam t_result UNTYPED   = '{KIND_ACK, 16'h0000, 1'b0, 9'd0, 1'b0};

    localparam int DIR_ROWS = 25;

    // timeout_ticks is 3 for this part, so the commit of the second packet
    // arms the timer and the third tick after it fires
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // empty ring after reset: fill query, peeks at both ends, idle tick
        '{'{REQ_FILL,   8'h00, 7'd0,   1'b0, 1'b0, 7'd0,   9'd0},   1'b1, ACK_EMPTY},
        '{'{REQ_PEEK_B, 8'h00, 7'd0,   1'b0, 1'b0, 7'd0,   9'd511}, 1'b1, PEEK_ZERO},
        '{'{REQ_PEEK_W, 8'h00, 7'd0,   1'b0, 1'b0, 7'd0,   9'd511}, 1'b1, PEEK_ZERO},
        '{'{REQ_TICK,   8'h00, 7'd0,   1'b0, 1'b0, 7'd0,   9'd0},   1'b1, ACK_EMPTY},
        // zero-length read and the undecoded request give a single ack
        '{'{REQ_READ,   8'h00, 7'd0,   1'b0, 1'b0, 7'd0,   9'd0},   1'b1, ACK_EMPTY},
        '{'{REQ_UNUSED, 8'hff, 7'd127, 1'b1, 1'b1, 7'd127, 9'd511}, 1'b1, ACK_EMPTY},
        // stray byte with no packet open
        '{'{REQ_BYTE,   8'h5a, 7'd3,   1'b0, 1'b0, 7'd0,   9'd0},   1'b1, ACK_EMPTY},
        // zero length and too long are both turned away
        '{'{REQ_BYTE,   8'h77, 7'd0,   1'b1, 1'b1, 7'd0,   9'd0},   1'b1, ACK_EMPTY},
        '{'{REQ_BYTE,   8'hff, 7'd127, 1'b1, 1'b1, 7'd0,   9'd0},   1'b1, ACK_EMPTY},
        // clean three byte packet with data extremes
        '{'{REQ_BYTE,   8'h00, 7'd3,   1'b1, 1'b0, 7'd0,   9'd0},   1'b0, UNTYPED},
        '{'{REQ_BYTE,   8'hff, 7'd3,   1'b0, 1'b0, 7'd0,   9'd0},   1'b0, UNTYPED},
        '{'{REQ_BYTE,   8'ha5, 7'd3,   1'b0, 1'b1, 7'd0,   9'd0},   1'b0, UNTYPED},
        // packet restarted before its end, then runs past its own length
        '{'{REQ_BYTE,   8'h11, 7'd4,   1'b1, 1'b0, 7'd0,   9'd0},   1'b0, UNTYPED},
        '{'{REQ_BYTE,   8'h22, 7'd2,   1'b1, 1'b0, 7'd0,   9'd0},   1'b0, UNTYPED},
        '{'{REQ_BYTE,   8'h33, 7'd2,   1'b0, 1'b0, 7'd0,   9'd0},   1'b0, UNTYPED},
        '{'{REQ_BYTE,   8'h44, 7'd2,   1'b0, 1'b0, 7'd0,   9'd0},   1'b0, UNTYPED},
        '{'{REQ_BYTE,   8'h55, 7'd2,   1'b0, 1'b1, 7'd0,   9'd0},   1'b0, UNTYPED},
        // count the idle timer out
        '{'{REQ_TICK,   8'h00, 7'd0,   1'b0, 1'b0, 7'd0,   9'd0},   1'b0, UNTYPED},
        '{'{REQ_TICK,   8'h00, 7'd0,   1'b0, 1'b0, 7'd0,   9'd0},   1'b0, UNTYPED},
        '{'{REQ_TICK,   8'h00, 7'd0,   1'b0, 1'b0, 7'd0,   9'd0},   1'b0, UNTYPED},
        // word peek, saturating read past the fill, flush, query, peek
        '{'{REQ_PEEK_W, 8'h00, 7'd0,   1'b0, 1'b0, 7'd0,   9'd2},   1'b0, UNTYPED},
        '{'{REQ_READ,   8'h00, 7'd0,   1'b0, 1'b0, 7'd127, 9'd0},   1'b0, UNTYPED},
        '{'{REQ_FLUSH,  8'h00, 7'd0,   1'b0, 1'b0, 7'd0,   9'd0},   1'b0, UNTYPED},
        '{'{REQ_FILL,   8'h00, 7'd0,   1'b0, 1'b0, 7'd0,   9'd0},   1'b0, UNTYPED},
        '{'{REQ_PEEK_B, 8'h00, 7'd0,   1'b0, 1'b0, 7'd0,   9'd0},   1'b0, UNTYPED}
    };

    localparam int PHASE_WORDS = 80;   // four random phases; with the table at least 345 words
    localparam int MAX_REPORTS = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic [2:0]  s_tuser = REQ_FILL;
    logic        m_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic [1:0]  o_m_axis_tuser;

    // no idling on either side while set
    bit calm = 1'b0;
    int mismatch_count = 0;
    int words_this_phase = 0;

    // shadow of the ring, its pointers, the packet in flight and the timer
    logic [BYTE_W-1:0] ring_mem [BUFFER_DEPTH];
    logic [ADDR_W-1:0] rd_ptr;
    logic [ADDR_W-1:0] wr_ptr;
    int                pkt_off;
    bit                pkt_taking;
    bit                tmr_armed;
    logic [TMR_W-1:0]  tmr_left;
    logic [TMR_W-1:0]  tmr_reload;

    // result words still owed by the block, oldest first
    t_result results_due[$];

    rx_byte_ring_with_idle_timeout dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // bytes held, write minus read around the ring
    function automatic logic [FILL_W-1:0] ring_fill();
        return FILL_W'(wr_ptr - rd_ptr);
    endfunction

    function automatic t_result ring_word(t_kind kind, logic [VALUE_W-1:0] value,
                                          logic last, logic accepted);
        t_result r;
        r.kind     = kind;
        r.value    = value;
        r.last     = last;
        r.fill     = ring_fill();
        r.accepted = accepted;
        return r;
    endfunction

    // advance the shadow by one accepted word and queue the results it owes
    function automatic void predict_ring_step(t_req_word w);
        int free_space;
        int n;
        logic [ADDR_W-1:0] start;
        logic stored;
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
        stored = 1'b0;
        case (w.req)
            REQ_BYTE: begin
                // the first byte decides for the whole packet
                if (w.first) begin
                    free_space = BUFFER_DEPTH - 1 - int'(ring_fill());
                    pkt_off    = 0;
                    pkt_taking = w.plen > 0 && w.plen <= MAX_PACKET && w.plen < free_space;
                end
                if (pkt_taking) begin
                    // bytes past the stated length or the packet limit are dropped
                    if (pkt_off < w.plen && pkt_off < MAX_PACKET) begin
                        ring_mem[ADDR_W'(wr_ptr + pkt_off)] = w.data;
                        pkt_off++;
                        stored = 1'b1;
                    end
                    if (w.last) begin
                        wr_ptr     = ADDR_W'(wr_ptr + pkt_off);
                        pkt_taking = 1'b0;
                        pkt_off    = 0;
                        tmr_armed  = tmr_reload != 0;
                        if (tmr_reload != 0) begin
                            tmr_left = tmr_reload;
                        end
                    end
                end
                results_due.push_back(ring_word(KIND_ACK, '0, 1'b1, stored));
            end
            REQ_TICK: begin
                if (tmr_armed && tmr_left <= 1) begin
                    tmr_left  = '0;
                    tmr_armed = 1'b0;
                    results_due.push_back(ring_word(KIND_TIMEOUT, VALUE_W'(ring_fill()),
                                                    1'b1, 1'b0));
                end else begin
                    if (tmr_armed) begin
                        tmr_left--;
                    end
                    results_due.push_back(ring_word(KIND_ACK, '0, 1'b1, 1'b0));
                end
            end
            REQ_READ: begin
                // pops saturate at the packet limit and do not look at the fill
                n = (w.rlen > MAX_PACKET) ? MAX_PACKET : int'(w.rlen);
                if (n == 0) begin
                    results_due.push_back(ring_word(KIND_ACK, '0, 1'b1, 1'b0));
                end else begin
                    start  = rd_ptr;
                    rd_ptr = ADDR_W'(rd_ptr + n);
                    for (int i = 0; i < n; i++) begin
                        results_due.push_back(ring_word(KIND_READ,
                            VALUE_W'(ring_mem[ADDR_W'(start + i)]), i == n - 1, 1'b0));
                    end
                end
            end
            REQ_PEEK_B: begin
                lo = VALUE_W'(ring_mem[ADDR_W'(rd_ptr + w.poff)]);
                results_due.push_back(ring_word(KIND_PEEK, lo, 1'b1, 1'b0));
            end
            REQ_PEEK_W: begin
                lo = VALUE_W'(ring_mem[ADDR_W'(rd_ptr + w.poff)]);
                hi = VALUE_W'(ring_mem[ADDR_W'(rd_ptr + w.poff + 1)]);
                results_due.push_back(ring_word(KIND_PEEK, (hi << 8) | lo, 1'b1, 1'b0));
            end
            REQ_FLUSH: begin
                rd_ptr = wr_ptr;
                results_due.push_back(ring_word(KIND_ACK, '0, 1'b1, 1'b0));
            end
            REQ_FILL: begin
                results_due.push_back(ring_word(KIND_ACK, VALUE_W'(ring_fill()), 1'b1, 1'b0));
            end
            default: begin
                results_due.push_back(ring_word(KIND_ACK, '0, 1'b1, 1'b0));
            end
        endcase
    endfunction

    // all fields random; callers overwrite the ones that matter
    function automatic t_req_word noise_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(t_req_word)-1:0];
    endfunction

    // present one word, with a random gap in front, and wait for the handshake
    task automatic push_word(input t_req_word w, input bit counts);
        while (!calm && $urandom_range(99) < 28) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_tdata <= {w.poff, w.rlen, w.first, w.plen, w.data};
        s_tlast <= w.last;
        s_tuser <= w.req;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_ring_step(w);
        if (counts) begin
            words_this_phase++;
        end
    endtask

    // register writes only with the input quiet
    task automatic write_timeout(input logic [TMR_W-1:0] ticks);
        cfg_we    <= 1'b1;
        cfg_wdata <= ticks;
        @(posedge i_clk);
        cfg_we     <= 1'b0;
        tmr_reload = ticks;
        tmr_armed  = 1'b0;
    endtask

    // let every owed result come back, then keep waiting so that peeks in flight settle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_packet(input int plen, input int n_bytes, input bit with_last);
        t_req_word w;
        for (int k = 0; k < n_bytes; k++) begin
            w       = noise_word();
            w.req   = REQ_BYTE;
            w.plen  = LEN_W'(plen);
            w.first = k == 0;
            w.last  = with_last && k == n_bytes - 1;
            push_word(w, 1'b1);
        end
    endtask

    // one random action: mostly whole packets and reads, some broken traffic
    task automatic random_action();
        t_req_word w;
        int sel;
        int plen;
        sel = $urandom_range(99);
        w   = noise_word();
        if (sel < 40) begin
            plen = ($urandom_range(9) == 0) ? MAX_PACKET : $urandom_range(1, MAX_PACKET);
            send_packet(plen, plen, 1'b1);
        end else if (sel < 47) begin
            case ($urandom_range(3))
                0: begin
                    // bad length, rejected at the first byte
                    plen = ($urandom_range(1) == 0) ? 0 : $urandom_range(MAX_PACKET + 1, 127);
                    send_packet(plen, $urandom_range(1, 3), 1'b1);
                end
                1: begin
                    // cut short, the next first byte restarts
                    plen = $urandom_range(2, MAX_PACKET);
                    send_packet(plen, $urandom_range(1, plen - 1), 1'b0);
                end
                2: begin
                    // runs past its stated length
                    plen = $urandom_range(1, 8);
                    send_packet(plen, plen + $urandom_range(1, 3), 1'b1);
                end
                default: begin
                    w.req   = REQ_BYTE;
                    w.first = 1'b0;
                    push_word(w, 1'b0);
                end
            endcase
        end else if (sel < 61) begin
            repeat ($urandom_range(1, 6)) begin
                w     = noise_word();
                w.req = REQ_TICK;
                push_word(w, 1'b1);
            end
        end else if (sel < 73) begin
            w.req  = REQ_READ;
            w.rlen = ($urandom_range(7) == 0) ? LEN_W'($urandom_range(127))
                                              : LEN_W'($urandom_range(24));
            push_word(w, 1'b1);
        end else if (sel < 85) begin
            w.req = ($urandom_range(1) == 0) ? REQ_PEEK_B : REQ_PEEK_W;
            if ($urandom_range(1) == 0) begin
                w.poff = POFF_W'($urandom_range(70));
            end
            push_word(w, 1'b1);
        end else if (sel < 88) begin
            w.req = REQ_FLUSH;
            push_word(w, 1'b1);
        end else if (sel < 95) begin
            w.req = REQ_FILL;
            push_word(w, 1'b1);
        end else begin
            w.req = REQ_UNUSED;
            push_word(w, 1'b1);
        end
    endtask

    // result side stalls at random except in the calm stretch
    always @(posedge i_clk) begin
        m_ready <= calm || $urandom_range(99) >= 28;
    end

    // compare each result word with the oldest one owed
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            got.kind     = t_kind'(o_m_axis_tuser);
            got.value    = o_m_axis_tdata[15:0];
            got.last     = o_m_axis_tlast;
            got.fill     = o_m_axis_tdata[24:16];
            got.accepted = o_m_axis_tdata[25];
            if (results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t: expected no result, got kind %0d value %h fill %0d", $time,
                             got.kind, got.value, got.fill);
                end
            end else begin
                want = results_due.pop_front();
                if (got !== want || o_m_axis_tdata[31:26] !== '0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: want %0d %h %0b %0d %0b got %0d %h %0b %0d %0b pad %h",
                                 $time, want.kind, want.value, want.last, want.fill,
                                 want.accepted, got.kind, got.value, got.last, got.fill,
                                 got.accepted, o_m_axis_tdata[31:26]);
                    end
                end
            end
        end
    end

    initial begin
        logic [TMR_W-1:0] phase_ticks;
        for (int i = 0; i < BUFFER_DEPTH; i++) begin
            ring_mem[i] = '0;
        end
        rd_ptr     = '0;
        wr_ptr     = '0;
        pkt_off    = 0;
        pkt_taking = 1'b0;
        tmr_armed  = 1'b0;
        tmr_left   = '0;
        tmr_reload = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // written while the ring is still being swept
        write_timeout(16'd3);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            push_word(DIR_TABLE[r].w, 1'b1);
            if (DIR_TABLE[r].typed) begin
                results_due[results_due.size() - 1] = DIR_TABLE[r].want;
            end
        end
        drain_results();

        // random phases: largest timeout, disabled, expire on first tick, short
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: phase_ticks = 16'hffff;
                1: phase_ticks = 16'd0;
                2: phase_ticks = 16'd1;
                default: phase_ticks = TMR_W'($urandom_range(2, 40));
            endcase
            write_timeout(phase_ticks);
            // one whole phase with both sides streaming back to back
            calm = phase == 2;
            words_this_phase = 0;
            while (words_this_phase < PHASE_WORDS) begin
                random_action();
            end
            drain_results();
            calm = 1'b0;
        end

        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
